// ----- rtl/channel_hop_activity_monitor_macros.svh -----
// ----------------------------------------------------------------------------
// channel_hop_activity_monitor assertion macros
// Shared concurrent assertion wrappers for the monitor checker.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_HOP_ACTIVITY_MONITOR_MACROS_SVH
`define CHANNEL_HOP_ACTIVITY_MONITOR_MACROS_SVH

// checked only outside reset
`define CHM_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("channel hop monitor check failed");

// checked during reset as well
`define CHM_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("channel hop monitor reset check failed");

`endif

// ----- rtl/chm_pkg.sv -----
// ----------------------------------------------------------------------------
// chm_pkg
// Types and constants shared by the channel hop activity monitor.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int CH_W    = 4;
    localparam int RATE_W  = 28;
    localparam int RSSI_W  = 8;
    localparam int CNT_W   = 32;
    localparam int PKT_W   = 24;
    localparam int TICK_W  = 16;
    localparam int NUM_W   = 42;
    localparam int MIX_W   = 37;
    localparam int DCNT_W  = 6;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [RATE_W-1:0]        RATE_MAX   = '1;
    localparam logic [PKT_W-1:0]         PKT_MAX    = '1;
    localparam logic [TICK_W-1:0]        TICK_MAX   = '1;
    localparam logic signed [RSSI_W-1:0] NO_RSSI    = -8'sd127;
    localparam logic [17:0]              RATE_SCALE = 18'd256000;
    localparam logic [7:0]               SMOOTH_OLD = 8'd154;
    localparam logic [7:0]               SMOOTH_NEW = 8'd102;
    localparam logic [DCNT_W-1:0]        DIV_LAST   = DCNT_W'(NUM_W - 1);
    localparam logic [TICK_W-1:0]        HOP_TICKS_RST = 16'd150;

    localparam logic REG_HOP_TICKS = 1'b0;
    localparam logic REG_CAPTURE   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_COMMIT,
        ST_SCAN,
        ST_EMIT
    } chm_state_t;

    typedef struct packed {
        logic take;
        logic mul;
        logic div_step;
        logic commit;
        logic scan_step;
        logic load_out;
    } chm_cmd_t;

    typedef struct packed {
        logic hop_now;
        logic div_last;
        logic scan_last;
        logic out_free;
    } chm_stat_t;

endpackage

// ----- rtl/chm_ctrl.sv -----
// ----------------------------------------------------------------------------
// chm_ctrl
// Sequencer: item accept, rate divide, channel commit, scan and emit.
// ----------------------------------------------------------------------------
module chm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  chm_pkg::chm_stat_t stat,
    output chm_pkg::chm_cmd_t  cmd
);

    chm_pkg::chm_state_t state_reg;
    chm_pkg::chm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= chm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            chm_pkg::ST_IDLE: begin
                if (s_valid && stat.hop_now) begin
                    state_next = chm_pkg::ST_MUL;
                end
            end
            chm_pkg::ST_MUL: begin
                state_next = chm_pkg::ST_DIV;
            end
            chm_pkg::ST_DIV: begin
                if (stat.div_last) begin
                    state_next = chm_pkg::ST_COMMIT;
                end
            end
            chm_pkg::ST_COMMIT: begin
                state_next = chm_pkg::ST_SCAN;
            end
            chm_pkg::ST_SCAN: begin
                if (stat.scan_last) begin
                    state_next = chm_pkg::ST_EMIT;
                end
            end
            chm_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    state_next = chm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = chm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            chm_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            chm_pkg::ST_MUL: begin
                cmd.mul = 1'b1;
            end
            chm_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            chm_pkg::ST_COMMIT: begin
                cmd.commit = 1'b1;
            end
            chm_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            chm_pkg::ST_EMIT: begin
                cmd.load_out = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/chm_dpath.sv -----
// ----------------------------------------------------------------------------
// chm_dpath
// Dwell counters, per-channel tables, rate divider, smoothing, scan and
// output register.
// ----------------------------------------------------------------------------
module chm_dpath #(
    parameter int NUM_CHANNELS = 13
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  chm_pkg::chm_cmd_t                     cmd,
    output chm_pkg::chm_stat_t                    stat,
    input  logic [chm_pkg::TICK_W-1:0]            hop_ticks,
    input  logic                                  capture_enable,
    input  logic                                  s_mode,
    input  logic signed [chm_pkg::RSSI_W-1:0]     s_rssi,
    input  logic                                  m_ready,
    output logic                                  m_valid,
    output logic [chm_pkg::CH_W-1:0]              m_tuned_channel,
    output logic [chm_pkg::RATE_W-1:0]            m_tuned_rate,
    output logic signed [chm_pkg::RSSI_W-1:0]     m_tuned_peak_rssi,
    output logic [chm_pkg::CNT_W-1:0]             m_tuned_total,
    output logic [chm_pkg::CNT_W-1:0]             m_grand_total,
    output logic [chm_pkg::CH_W-1:0]              m_busiest_channel,
    output logic [chm_pkg::RATE_W-1:0]            m_busiest_rate,
    output logic [chm_pkg::CH_W-1:0]              m_quietest_channel,
    output logic [chm_pkg::RATE_W-1:0]            m_quietest_rate
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

    logic [chm_pkg::RATE_W-1:0]        rate_reg  [NUM_CHANNELS];
    logic signed [chm_pkg::RSSI_W-1:0] peak_reg  [NUM_CHANNELS];
    logic [chm_pkg::CNT_W-1:0]         total_reg [NUM_CHANNELS];

    logic [chm_pkg::CNT_W-1:0]         all_count_reg;
    logic [IDX_W-1:0]                  cur_idx_reg;
    logic [chm_pkg::PKT_W-1:0]         pkts_reg;
    logic signed [chm_pkg::RSSI_W-1:0] max_rssi_reg;
    logic [chm_pkg::TICK_W-1:0]        ticks_reg;

    logic [chm_pkg::NUM_W-1:0]         dq_reg;
    logic [chm_pkg::TICK_W-1:0]        rem_reg;
    logic [chm_pkg::DCNT_W-1:0]        div_cnt_reg;

    logic [IDX_W-1:0]                  scan_idx_reg;
    logic [IDX_W-1:0]                  best_idx_reg;
    logic [chm_pkg::RATE_W-1:0]        best_rate_reg;
    logic [IDX_W-1:0]                  quiet_idx_reg;
    logic [chm_pkg::RATE_W-1:0]        quiet_rate_reg;
    logic [chm_pkg::RATE_W-1:0]        tun_rate_reg;
    logic signed [chm_pkg::RSSI_W-1:0] tun_peak_reg;
    logic [chm_pkg::CNT_W-1:0]         tun_total_reg;

    logic                              m_valid_reg;
    logic [chm_pkg::CH_W-1:0]          o_tch_reg;
    logic [chm_pkg::RATE_W-1:0]        o_trate_reg;
    logic signed [chm_pkg::RSSI_W-1:0] o_tpeak_reg;
    logic [chm_pkg::CNT_W-1:0]         o_ttotal_reg;
    logic [chm_pkg::CNT_W-1:0]         o_gtotal_reg;
    logic [chm_pkg::CH_W-1:0]          o_bch_reg;
    logic [chm_pkg::RATE_W-1:0]        o_brate_reg;
    logic [chm_pkg::CH_W-1:0]          o_qch_reg;
    logic [chm_pkg::RATE_W-1:0]        o_qrate_reg;

    logic [chm_pkg::TICK_W-1:0]        ticks_inc;
    logic [chm_pkg::TICK_W-1:0]        limit;
    logic [chm_pkg::TICK_W:0]          trial;
    logic                              trial_ge;
    logic [chm_pkg::TICK_W-1:0]        rem_next;
    logic [IDX_W-1:0]                  rd_idx;
    logic [chm_pkg::RATE_W-1:0]        rd_rate;
    logic signed [chm_pkg::RSSI_W-1:0] rd_peak;
    logic [chm_pkg::CNT_W-1:0]         rd_total;
    logic [chm_pkg::RATE_W-1:0]        fresh;
    logic [chm_pkg::MIX_W-1:0]         mix;
    logic [IDX_W-1:0]                  next_idx;

    assign ticks_inc = (ticks_reg == chm_pkg::TICK_MAX) ? ticks_reg
                                                         : ticks_reg + 16'd1;
    assign limit     = (hop_ticks == '0) ? 16'd1 : hop_ticks;

    assign trial    = {rem_reg, dq_reg[chm_pkg::NUM_W-1]};
    assign trial_ge = trial >= {1'b0, ticks_reg};
    assign rem_next = trial_ge ? chm_pkg::TICK_W'(trial - {1'b0, ticks_reg})
                               : trial[chm_pkg::TICK_W-1:0];

    assign rd_idx   = cmd.scan_step ? scan_idx_reg : cur_idx_reg;
    assign rd_rate  = rate_reg[rd_idx];
    assign rd_peak  = peak_reg[rd_idx];
    assign rd_total = total_reg[rd_idx];

    // a dwell of one tick reports zero
    assign fresh = (ticks_reg <= 16'd1) ? '0 :
                   (|dq_reg[chm_pkg::NUM_W-1:chm_pkg::RATE_W]) ? chm_pkg::RATE_MAX :
                   dq_reg[chm_pkg::RATE_W-1:0];

    assign mix = chm_pkg::MIX_W'(rd_rate) * chm_pkg::MIX_W'(chm_pkg::SMOOTH_OLD)
               + chm_pkg::MIX_W'(fresh) * chm_pkg::MIX_W'(chm_pkg::SMOOTH_NEW);

    assign next_idx = (cur_idx_reg == LAST_IDX) ? '0 : cur_idx_reg + IDX_W'(1);

    assign stat.hop_now   = capture_enable && s_mode && (ticks_inc >= limit);
    assign stat.div_last  = div_cnt_reg == chm_pkg::DIV_LAST;
    assign stat.scan_last = scan_idx_reg == LAST_IDX;
    assign stat.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                rate_reg[i]  <= '0;
                peak_reg[i]  <= chm_pkg::NO_RSSI;
                total_reg[i] <= '0;
            end
            all_count_reg <= '0;
            cur_idx_reg   <= '0;
            pkts_reg      <= '0;
            max_rssi_reg  <= chm_pkg::NO_RSSI;
            ticks_reg     <= '0;
            div_cnt_reg   <= '0;
            scan_idx_reg  <= '0;
        end else begin
            if (cmd.take && capture_enable) begin
                if (!s_mode) begin
                    if (pkts_reg != chm_pkg::PKT_MAX) begin
                        pkts_reg <= pkts_reg + 24'd1;
                    end
                    if (s_rssi > max_rssi_reg) begin
                        max_rssi_reg <= s_rssi;
                    end
                end else begin
                    ticks_reg <= ticks_inc;
                end
            end
            if (cmd.mul) begin
                div_cnt_reg <= '0;
            end
            if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + 6'd1;
            end
            if (cmd.commit) begin
                rate_reg[cur_idx_reg]  <= mix[chm_pkg::RATE_W+7:8];
                total_reg[cur_idx_reg] <= rd_total + chm_pkg::CNT_W'(pkts_reg);
                if (max_rssi_reg > rd_peak) begin
                    peak_reg[cur_idx_reg] <= max_rssi_reg;
                end
                all_count_reg <= all_count_reg + chm_pkg::CNT_W'(pkts_reg);
                cur_idx_reg   <= next_idx;
                pkts_reg      <= '0;
                max_rssi_reg  <= chm_pkg::NO_RSSI;
                ticks_reg     <= '0;
                scan_idx_reg  <= '0;
            end
            if (cmd.scan_step && !stat.scan_last) begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
        end
    end

    // divider: one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            dq_reg  <= {18'b0, pkts_reg} * chm_pkg::NUM_W'(chm_pkg::RATE_SCALE);
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            dq_reg  <= {dq_reg[chm_pkg::NUM_W-2:0], trial_ge};
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_step) begin
            if (scan_idx_reg == '0) begin
                best_idx_reg   <= '0;
                best_rate_reg  <= rd_rate;
                quiet_idx_reg  <= '0;
                quiet_rate_reg <= rd_rate;
            end else begin
                if (rd_rate > best_rate_reg) begin
                    best_idx_reg  <= scan_idx_reg;
                    best_rate_reg <= rd_rate;
                end
                if (rd_rate < quiet_rate_reg) begin
                    quiet_idx_reg  <= scan_idx_reg;
                    quiet_rate_reg <= rd_rate;
                end
            end
            if (scan_idx_reg == cur_idx_reg) begin
                tun_rate_reg  <= rd_rate;
                tun_peak_reg  <= rd_peak;
                tun_total_reg <= rd_total;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            o_tch_reg    <= chm_pkg::CH_W'(cur_idx_reg) + 4'd1;
            o_trate_reg  <= tun_rate_reg;
            o_tpeak_reg  <= tun_peak_reg;
            o_ttotal_reg <= tun_total_reg;
            o_gtotal_reg <= all_count_reg;
            o_bch_reg    <= chm_pkg::CH_W'(best_idx_reg) + 4'd1;
            o_brate_reg  <= best_rate_reg;
            o_qch_reg    <= chm_pkg::CH_W'(quiet_idx_reg) + 4'd1;
            o_qrate_reg  <= quiet_rate_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_tuned_channel    = o_tch_reg;
    assign m_tuned_rate       = o_trate_reg;
    assign m_tuned_peak_rssi  = o_tpeak_reg;
    assign m_tuned_total      = o_ttotal_reg;
    assign m_grand_total      = o_gtotal_reg;
    assign m_busiest_channel  = o_bch_reg;
    assign m_busiest_rate     = o_brate_reg;
    assign m_quietest_channel = o_qch_reg;
    assign m_quietest_rate    = o_qrate_reg;

endmodule

// ----- rtl/channel_hop_activity_monitor.sv -----
// ----------------------------------------------------------------------------
// channel_hop_activity_monitor
// Per-channel packet activity statistics for a cyclic channel hopper.
// ----------------------------------------------------------------------------
// Input beats (s_valid/s_ready) carry either a captured packet (s_mode 0,
// with s_rssi) or a one-millisecond tick (s_mode 1). Packets and ticks that
// do not end a dwell are taken without a stall. The tick that reaches
// hop_ticks starts a hop: the rate product, a bit-serial divide, a commit,
// a scan over all channel table entries and an emit step that offers the
// result beat (m_valid/m_ready). s_ready stays low during a hop.
// The result sits in an output register; packets and ticks keep flowing
// while it waits. A following hop that finishes while the receiver still
// stalls holds in its emit state until the register frees.
// APB registers: 0x0 hop_ticks (16 bits, reset 150), 0x4 capture_enable
// (reset 1). Reset (aresetn low, synchronous) clears all channel tables and
// totals and tunes channel 1. With capture off, beats are taken and dropped.
// ----------------------------------------------------------------------------
module channel_hop_activity_monitor #(
    parameter int NUM_CHANNELS = 13
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [chm_pkg::ADDR_W-1:0]            paddr,
    input  logic [chm_pkg::DATA_W-1:0]            pwdata,
    output logic [chm_pkg::DATA_W-1:0]            prdata,
    output logic                                  pready,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_mode,
    input  logic signed [chm_pkg::RSSI_W-1:0]     s_rssi,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [chm_pkg::CH_W-1:0]              m_tuned_channel,
    output logic [chm_pkg::RATE_W-1:0]            m_tuned_rate,
    output logic signed [chm_pkg::RSSI_W-1:0]     m_tuned_peak_rssi,
    output logic [chm_pkg::CNT_W-1:0]             m_tuned_total,
    output logic [chm_pkg::CNT_W-1:0]             m_grand_total,
    output logic [chm_pkg::CH_W-1:0]              m_busiest_channel,
    output logic [chm_pkg::RATE_W-1:0]            m_busiest_rate,
    output logic [chm_pkg::CH_W-1:0]              m_quietest_channel,
    output logic [chm_pkg::RATE_W-1:0]            m_quietest_rate
);

    logic [chm_pkg::TICK_W-1:0] hop_ticks_reg;
    logic                       capture_reg;
    logic                       reg_idx;
    chm_pkg::chm_cmd_t          cmd;
    chm_pkg::chm_stat_t         stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hop_ticks_reg <= chm_pkg::HOP_TICKS_RST;
            capture_reg   <= 1'b1;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                chm_pkg::REG_HOP_TICKS: hop_ticks_reg <= pwdata[chm_pkg::TICK_W-1:0];
                chm_pkg::REG_CAPTURE:   capture_reg   <= pwdata[0];
                default: begin
                    capture_reg <= capture_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            chm_pkg::REG_HOP_TICKS: prdata = chm_pkg::DATA_W'(hop_ticks_reg);
            chm_pkg::REG_CAPTURE:   prdata = chm_pkg::DATA_W'(capture_reg);
            default:                prdata = '0;
        endcase
    end

    chm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    chm_dpath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .hop_ticks          (hop_ticks_reg),
        .capture_enable     (capture_reg),
        .s_mode             (s_mode),
        .s_rssi             (s_rssi),
        .m_ready            (m_ready),
        .m_valid            (m_valid),
        .m_tuned_channel    (m_tuned_channel),
        .m_tuned_rate       (m_tuned_rate),
        .m_tuned_peak_rssi  (m_tuned_peak_rssi),
        .m_tuned_total      (m_tuned_total),
        .m_grand_total      (m_grand_total),
        .m_busiest_channel  (m_busiest_channel),
        .m_busiest_rate     (m_busiest_rate),
        .m_quietest_channel (m_quietest_channel),
        .m_quietest_rate    (m_quietest_rate)
    );

endmodule

// ----- rtl/chm_checker.sv -----
// ----------------------------------------------------------------------------
// chm_checker
// Port-level checks for the channel hop activity monitor, bound to the top.
// ----------------------------------------------------------------------------
`include "channel_hop_activity_monitor_macros.svh"

module chm_checker #(
    parameter int NUM_CHANNELS = 13
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [chm_pkg::CH_W-1:0]         m_tuned_channel,
    input logic [chm_pkg::CNT_W-1:0]        m_tuned_total,
    input logic [chm_pkg::RATE_W-1:0]       m_busiest_rate,
    input logic [chm_pkg::RATE_W-1:0]       m_quietest_rate
);

    localparam logic [chm_pkg::CH_W-1:0] CH_LAST = chm_pkg::CH_W'(NUM_CHANNELS);

    `CHM_ASSERT_RST(a_no_beat_after_reset, !aresetn |=> !m_valid)

    `CHM_ASSERT(a_stall_holds, m_valid && !m_ready |=> m_valid && $stable(m_tuned_total))

    `CHM_ASSERT(a_busy_ge_quiet, m_valid |-> m_busiest_rate >= m_quietest_rate)

    `CHM_ASSERT(a_channel_range, m_valid |-> m_tuned_channel != '0 && m_tuned_channel <= CH_LAST)

endmodule

bind channel_hop_activity_monitor chm_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_chm_checker (.*);
